>>> src/gmlc_pkg.sv
// ----------------------------------------------------------------------------
// gmlc_pkg
// Shared types and codes of the Gaussian maximum-likelihood classifier.
// ----------------------------------------------------------------------------
package gmlc_pkg;

  // operation codes of an input item
  typedef enum logic [2:0] {
    OP_SAMPLE = 3'd0,
    OP_ID     = 3'd1,
    OP_BIAS   = 3'd2,
    OP_MEAN   = 3'd3,
    OP_INV    = 3'd4
  } op_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_BANDS   = 2'd0,
    CFG_CLASSES = 2'd1,
    CFG_NDEN    = 2'd2,
    CFG_NDVAL   = 2'd3
  } cfg_idx_t;

  localparam int CFG_DATA_W = 16;
  localparam int INV_W      = 32;
  localparam int BIAS_W     = 48;
  localparam int LABEL_W    = 16;

  typedef struct packed {
    logic [2:0]         operation;
    logic [15:0]        band_sample;
    logic [3:0]         table_class;
    logic [2:0]         table_row;
    logic [2:0]         table_col;
    logic signed [47:0] table_word;
  } in_item_t;

  typedef struct packed {
    logic [15:0] class_label;
    logic        unclassified;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // position flags of one multiply-accumulate step
  typedef struct packed {
    logic first_k;
    logic last_k;
    logic first_r;
    logic last_r;
    logic first_c;
    logic last_c;
    logic diag;
  } tag_t;

  // controller to datapath
  typedef struct packed {
    logic step;
    tag_t tag;
    logic pix_wr;
    logic tab_wr;
    logic load_res;
    logic res_nodata;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic nodata_hit;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

>>> src/gmlc_if.sv
// ----------------------------------------------------------------------------
// gmlc_in_if / gmlc_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface gmlc_in_if;
  import gmlc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gmlc_out_if;
  import gmlc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/gmlc_ctrl.sv
// ----------------------------------------------------------------------------
// gmlc_ctrl
// Controller: band counting, class/row/column sequencing, result hand-off.
// ----------------------------------------------------------------------------
module gmlc_ctrl #(
  parameter int MAX_BANDS   = 8,
  parameter int MAX_CLASSES = 16,
  localparam int BW  = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1,
  localparam int CW  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  gmlc_in_if.sink             in_if,
  input  logic [3:0]          bands_cfg,
  input  logic [4:0]          classes_cfg,
  input  gmlc_pkg::sts_t      sts,
  output gmlc_pkg::cmd_t      cmd,
  output logic [CW-1:0]       cmd_c,
  output logic [BW-1:0]       cmd_r,
  output logic [BW-1:0]       cmd_k
);
  import gmlc_pkg::*;

  localparam int BCW = $clog2(MAX_BANDS + 1);
  localparam int NCW = $clog2(MAX_CLASSES + 1);

  state_t        state_r, state_nxt;
  logic [BW-1:0] bcnt_r, bcnt_nxt;
  logic [CW-1:0] c_r, c_nxt;
  logic [BW-1:0] r_r, r_nxt;
  logic [BW-1:0] k_r, k_nxt;
  logic          nd_r, nd_nxt;
  logic [BCW-1:0] nb_c;
  logic [NCW-1:0] nc_c;
  logic [BCW-1:0] cnt_inc;
  logic          acc_in, is_sample;
  logic          last_k, last_r, last_c;

  // clamp the counts into range
  always_comb begin
    if (bands_cfg == 4'd0) begin
      nb_c = BCW'(1);
    end else if (int'(bands_cfg) > MAX_BANDS) begin
      nb_c = BCW'(MAX_BANDS);
    end else begin
      nb_c = BCW'(bands_cfg);
    end
    if (classes_cfg == 5'd0) begin
      nc_c = NCW'(1);
    end else if (int'(classes_cfg) > MAX_CLASSES) begin
      nc_c = NCW'(MAX_CLASSES);
    end else begin
      nc_c = NCW'(classes_cfg);
    end
  end

  assign acc_in    = in_if.valid && in_if.ready;
  assign is_sample = (in_if.data.operation == OP_SAMPLE);
  assign cnt_inc   = BCW'(bcnt_r) + BCW'(1);
  assign last_k    = (BCW'(k_r) == nb_c - BCW'(1));
  assign last_r    = (BCW'(r_r) == nb_c - BCW'(1));
  assign last_c    = (NCW'(c_r) == nc_c - NCW'(1));

  assign in_if.ready = (state_r == ST_IDLE);
  assign cmd_c = c_r;
  assign cmd_r = r_r;
  assign cmd_k = (state_r == ST_RUN) ? k_r : bcnt_r;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      bcnt_r  <= '0;
      c_r     <= '0;
      r_r     <= '0;
      k_r     <= '0;
      nd_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bcnt_r  <= bcnt_nxt;
      c_r     <= c_nxt;
      r_r     <= r_nxt;
      k_r     <= k_nxt;
      nd_r    <= nd_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    bcnt_nxt  = bcnt_r;
    c_nxt     = c_r;
    r_nxt     = r_r;
    k_nxt     = k_r;
    nd_nxt    = nd_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (acc_in) begin
          if (is_sample) begin
            cmd.pix_wr = 1'b1;
            if (cnt_inc >= nb_c) begin
              bcnt_nxt  = '0;
              state_nxt = ST_CHECK;
            end else begin
              bcnt_nxt = cnt_inc[BW-1:0];
            end
          end else begin
            cmd.tab_wr = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        c_nxt = '0;
        r_nxt = '0;
        k_nxt = '0;
        if (sts.nodata_hit) begin
          nd_nxt    = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          nd_nxt    = 1'b0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.step        = 1'b1;
        cmd.tag.first_k = (k_r == '0);
        cmd.tag.last_k  = last_k;
        cmd.tag.first_r = (r_r == '0);
        cmd.tag.last_r  = last_r;
        cmd.tag.first_c = (c_r == '0);
        cmd.tag.last_c  = last_c;
        cmd.tag.diag    = (k_r == r_r);
        if (last_k) begin
          k_nxt = '0;
          if (last_r) begin
            r_nxt = '0;
            if (last_c) begin
              state_nxt = ST_DRAIN;
            end else begin
              c_nxt = c_r + CW'(1);
            end
          end else begin
            r_nxt = r_r + BW'(1);
          end
        end else begin
          k_nxt = k_r + BW'(1);
        end
      end
      ST_DRAIN: begin
        if (sts.scan_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_res   = 1'b1;
          cmd.res_nodata = nd_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/gmlc_dpath.sv
// ----------------------------------------------------------------------------
// gmlc_dpath
// Datapath: class tables, pixel buffer, multiply-accumulate pipeline, argmax.
// ----------------------------------------------------------------------------
module gmlc_dpath #(
  parameter int MAX_BANDS   = 8,
  parameter int MAX_CLASSES = 16,
  parameter int SAMPLE_BITS = 16,
  localparam int BW  = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1,
  localparam int CW  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gmlc_pkg::in_item_t item,
  input  gmlc_pkg::cmd_t     cmd,
  input  logic [CW-1:0]      cmd_c,
  input  logic [BW-1:0]      cmd_r,
  input  logic [BW-1:0]      cmd_k,
  input  logic               nodata_en,
  input  logic [15:0]        nodata_val,
  output gmlc_pkg::sts_t     sts,
  gmlc_out_if.source         out_if
);
  import gmlc_pkg::*;

  localparam int MEAN_D  = MAX_CLASSES * MAX_BANDS;
  localparam int INV_D   = MAX_CLASSES * MAX_BANDS * MAX_BANDS;
  localparam int MEAN_AW = (MEAN_D > 1) ? $clog2(MEAN_D) : 1;
  localparam int INV_AW  = (INV_D > 1) ? $clog2(INV_D) : 1;
  localparam int DIFF_W  = SAMPLE_BITS + 1;
  localparam int PROD_W  = INV_W + DIFF_W;
  localparam int ACC_W   = PROD_W + BW + 1;
  localparam int ROW_W   = ACC_W - 15;
  localparam int TERM_W  = DIFF_W + ROW_W;
  localparam int DIST_W  = TERM_W + BW + 1;
  localparam int SCORE_W = ((DIST_W > BIAS_W + 1) ? DIST_W : BIAS_W + 1) + 1;

  // storage
  logic [SAMPLE_BITS-1:0]   pix_r   [MAX_BANDS];
  logic [LABEL_W-1:0]       id_mem  [MAX_CLASSES];
  logic signed [BIAS_W-1:0] bias_mem[MAX_CLASSES];
  logic [SAMPLE_BITS-1:0]   mean_mem[MEAN_D];
  logic signed [INV_W-1:0]  inv_mem [INV_D];

  logic cls_ok, row_ok, col_ok;
  logic [MEAN_AW-1:0] mean_wa, mean_ra;
  logic [INV_AW-1:0]  inv_wa, inv_ra;
  logic [CW-1:0]      wcls;

  // stage 1
  logic                     v1_r;
  tag_t                     tag1_r;
  logic [SAMPLE_BITS-1:0]   x1_r, mean1_r;
  logic signed [INV_W-1:0]  inv1_r;
  logic signed [BIAS_W-1:0] bias1_r;
  logic [LABEL_W-1:0]       id1_r;
  // stage 2
  logic                     v2_r;
  tag_t                     tag2_r;
  logic signed [DIFF_W-1:0] diff2_r;
  logic signed [PROD_W-1:0] prod2_r;
  logic signed [BIAS_W-1:0] bias2_r;
  logic [LABEL_W-1:0]       id2_r;
  logic signed [DIFF_W-1:0] diff_c;
  // stage 3
  logic signed [ACC_W-1:0]  acc_r, acc_sum;
  logic signed [ACC_W:0]    acc_rnd;
  logic signed [DIFF_W-1:0] dsave_r;
  logic                     v3_r;
  tag_t                     tag3_r;
  logic signed [ROW_W-1:0]  row3_r;
  logic signed [DIFF_W-1:0] pdiff3_r;
  logic signed [BIAS_W-1:0] bias3_r;
  logic [LABEL_W-1:0]       id3_r;
  // stage 4
  logic                     v4_r;
  tag_t                     tag4_r;
  logic signed [TERM_W-1:0] term4_r;
  logic signed [BIAS_W-1:0] bias4_r;
  logic [LABEL_W-1:0]       id4_r;
  // stage 5
  logic signed [DIST_W-1:0]  dist_r, dist_sum;
  logic                      v5_r;
  tag_t                      tag5_r;
  logic signed [SCORE_W-1:0] score5_r;
  logic [LABEL_W-1:0]        id5_r;
  // stage 6
  logic signed [SCORE_W-1:0] best_r;
  logic [LABEL_W-1:0]        label_r;
  logic                      done_r;
  // result register
  logic                      ovalid_r;
  out_item_t                 odata_r;

  // load address decode
  assign cls_ok  = int'(item.table_class) < MAX_CLASSES;
  assign row_ok  = int'(item.table_row) < MAX_BANDS;
  assign col_ok  = int'(item.table_col) < MAX_BANDS;
  assign wcls    = CW'(item.table_class);
  assign mean_wa = MEAN_AW'(int'(item.table_class) * MAX_BANDS + int'(item.table_row));
  assign inv_wa  = INV_AW'((int'(item.table_class) * MAX_BANDS + int'(item.table_row))
                   * MAX_BANDS + int'(item.table_col));
  assign mean_ra = MEAN_AW'(int'(cmd_c) * MAX_BANDS + int'(cmd_k));
  assign inv_ra  = INV_AW'((int'(cmd_c) * MAX_BANDS + int'(cmd_r)) * MAX_BANDS
                   + int'(cmd_k));

  // table writes
  always_ff @(posedge clk) begin
    if (cmd.tab_wr && cls_ok) begin
      unique case (item.operation)
        OP_ID:   id_mem[wcls]   <= item.table_word[LABEL_W-1:0];
        OP_BIAS: bias_mem[wcls] <= item.table_word;
        OP_MEAN: begin
          if (row_ok) begin
            mean_mem[mean_wa] <= item.table_word[SAMPLE_BITS-1:0];
          end
        end
        OP_INV: begin
          if (row_ok && col_ok) begin
            inv_mem[inv_wa] <= item.table_word[INV_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // pixel buffer
  always_ff @(posedge clk) begin
    if (cmd.pix_wr) begin
      pix_r[cmd_k] <= item.band_sample[SAMPLE_BITS-1:0];
    end
  end

  assign sts.nodata_hit = nodata_en && (16'(pix_r[0]) == nodata_val);

  // stage 1: table reads
  always_ff @(posedge clk) begin
    mean1_r <= mean_mem[mean_ra];
    inv1_r  <= inv_mem[inv_ra];
    bias1_r <= bias_mem[cmd_c];
    id1_r   <= id_mem[cmd_c];
    x1_r    <= pix_r[cmd_k];
    tag1_r  <= cmd.tag;
  end

  // stage 2: difference and product
  assign diff_c = $signed({1'b0, x1_r}) - $signed({1'b0, mean1_r});

  always_ff @(posedge clk) begin
    diff2_r <= diff_c;
    prod2_r <= PROD_W'(inv1_r) * PROD_W'(diff_c);
    tag2_r  <= tag1_r;
    bias2_r <= bias1_r;
    id2_r   <= id1_r;
  end

  // stage 3: row accumulation and rounding from q.16 to integer
  assign acc_sum = (tag2_r.first_k ? ACC_W'(0) : acc_r) + ACC_W'(prod2_r);
  assign acc_rnd = (ACC_W + 1)'(acc_sum) + (ACC_W + 1)'(32768);

  always_ff @(posedge clk) begin
    if (v2_r) begin
      acc_r <= acc_sum;
      if (tag2_r.diag) begin
        dsave_r <= diff2_r;
      end
    end
    row3_r   <= ROW_W'(acc_rnd >>> 16);
    pdiff3_r <= tag2_r.diag ? diff2_r : dsave_r;
    tag3_r   <= tag2_r;
    bias3_r  <= bias2_r;
    id3_r    <= id2_r;
  end

  // stage 4: distance term
  always_ff @(posedge clk) begin
    term4_r <= TERM_W'(pdiff3_r) * TERM_W'(row3_r);
    tag4_r  <= tag3_r;
    bias4_r <= bias3_r;
    id4_r   <= id3_r;
  end

  // stage 5: distance sum and score
  assign dist_sum = (tag4_r.first_r ? DIST_W'(0) : dist_r) + DIST_W'(term4_r);

  always_ff @(posedge clk) begin
    if (v4_r) begin
      dist_r <= dist_sum;
    end
    score5_r <= (SCORE_W'(bias4_r) <<< 1) - SCORE_W'(dist_sum);
    tag5_r   <= tag4_r;
    id5_r    <= id4_r;
  end

  // stage 6: best class, first one wins ties
  always_ff @(posedge clk) begin
    if (v5_r && (tag5_r.first_c || (score5_r > best_r))) begin
      best_r  <= score5_r;
      label_r <= id5_r;
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
      v5_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= cmd.step;
      v2_r   <= v1_r;
      v3_r   <= v2_r && tag2_r.last_k;
      v4_r   <= v3_r;
      v5_r   <= v4_r && tag4_r.last_r;
      done_r <= v5_r && tag5_r.last_c;
    end
  end

  assign sts.scan_done = done_r;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd.load_res) begin
      ovalid_r <= 1'b1;
    end else if (out_if.ready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_res) begin
      odata_r.class_label  <= cmd.res_nodata ? '0 : label_r;
      odata_r.unclassified <= cmd.res_nodata;
    end
  end

  assign sts.out_free = !ovalid_r || out_if.ready;
  assign out_if.valid = ovalid_r;
  assign out_if.data  = odata_r;

endmodule

>>> src/gaussian_max_likelihood_classifier.sv
// ----------------------------------------------------------------------------
// gaussian_max_likelihood_classifier
// Per-pixel Gaussian maximum-likelihood classifier, top level.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries load items (class id, bias, mean, inverse entry) and pixel
//   samples, one band per item. Loads and all but the last band are accepted while idle.
//   After the last band of a pixel one result goes out on out_if: the label of
//   the best class, or label 0 with unclassified set on a no-data pixel.
//   The last band starts a scan on one shared multiply-accumulate unit that
//   takes one step per class, row and column; in_if is not ready during the
//   scan. The result register lets the next pixel load while the result
//   waits; a scan that ends with the result still untaken holds until out_if
//   takes it.
//   cfg_we/cfg_index/cfg_data write the four settings; they are to be written
//   only while idle, which the block itself does not enforce.
//   Reset (rst_n low, synchronous) clears the band counter, the settings to
//   one band, one class, no-data off, and drops any pending result. Tables
//   hold unknown contents until loaded.
// ----------------------------------------------------------------------------
module gaussian_max_likelihood_classifier #(
  parameter int MAX_BANDS   = 8,
  parameter int MAX_CLASSES = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  gmlc_in_if.sink                             in_if,
  gmlc_out_if.source                          out_if,
  input  logic                                cfg_we,
  input  gmlc_pkg::cfg_idx_t                  cfg_index,
  input  logic [gmlc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import gmlc_pkg::*;

  localparam int BW = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
  localparam int CW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;

  logic [3:0]  bands_r;
  logic [4:0]  classes_r;
  logic        nden_r;
  logic [15:0] ndval_r;

  cmd_t          cmd;
  sts_t          sts;
  logic [CW-1:0] cmd_c;
  logic [BW-1:0] cmd_r;
  logic [BW-1:0] cmd_k;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bands_r   <= 4'd1;
      classes_r <= 5'd1;
      nden_r    <= 1'b0;
      ndval_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BANDS:   bands_r   <= cfg_data[3:0];
        CFG_CLASSES: classes_r <= cfg_data[4:0];
        CFG_NDEN:    nden_r    <= cfg_data[0];
        CFG_NDVAL:   ndval_r   <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  gmlc_ctrl #(
    .MAX_BANDS   (MAX_BANDS),
    .MAX_CLASSES (MAX_CLASSES)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_if),
    .bands_cfg   (bands_r),
    .classes_cfg (classes_r),
    .sts         (sts),
    .cmd         (cmd),
    .cmd_c       (cmd_c),
    .cmd_r       (cmd_r),
    .cmd_k       (cmd_k)
  );

  gmlc_dpath #(
    .MAX_BANDS   (MAX_BANDS),
    .MAX_CLASSES (MAX_CLASSES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (in_if.data),
    .cmd        (cmd),
    .cmd_c      (cmd_c),
    .cmd_r      (cmd_r),
    .cmd_k      (cmd_k),
    .nodata_en  (nden_r),
    .nodata_val (ndval_r),
    .sts        (sts),
    .out_if     (out_if)
  );

endmodule

>>> verif/tb_gaussian_max_likelihood_classifier.sv
// ----------------------------------------------------------------------------
// tb_gaussian_max_likelihood_classifier
// Loads every class slot, then drives pixel samples, table updates and
// ignored codes under random settings and random gaps on both channels.
// A scoreboard scores each finished pixel itself and compares every
// result item with the oldest expected label.
// ----------------------------------------------------------------------------
import gmlc_pkg::*;

class gmlc_scoreboard;
  logic [3:0]  bands_cfg;
  logic [4:0]  classes_cfg;
  logic        nodata_on;
  logic [15:0] nodata_val;

  logic [15:0] pixel [8];
  int unsigned band_idx;
  logic [15:0] ids [16];
  longint      bias [16];
  logic [15:0] means [16][8];
  longint      inv [16][8][8];

  out_item_t   pending_labels [$];
  int          errors;
  int          results_seen;
  int          nodata_seen;
  int          loads_seen;
  int          samples_seen;

  function new();
    bands_cfg   = 4'd1;
    classes_cfg = 5'd1;
    nodata_on   = 1'b0;
    nodata_val  = '0;
    band_idx    = 0;
    errors      = 0;
    results_seen = 0;
    nodata_seen = 0;
    loads_seen  = 0;
    samples_seen = 0;
  endfunction

  function void write_reg(cfg_idx_t idx, logic [15:0] v);
    case (idx)
      CFG_BANDS:   bands_cfg   = v[3:0];
      CFG_CLASSES: classes_cfg = v[4:0];
      CFG_NDEN:    nodata_on   = v[0];
      CFG_NDVAL:   nodata_val  = v;
      default: ;
    endcase
  endfunction

  function int unsigned band_count();
    if (bands_cfg == 0) return 1;
    if (bands_cfg > 8) return 8;
    return bands_cfg;
  endfunction

  // append one expected result at the tail
  function void queue_label(out_item_t lbl);
    pending_labels = {pending_labels, lbl};
  endfunction

  // score every class in use, highest score wins, lowest slot on a tie
  function out_item_t best_label();
    int unsigned nb;
    int unsigned nc;
    longint      diff [8];
    longint      row_sum;
    longint      mahal;
    longint      score;
    longint      best;
    out_item_t   r;
    nb = band_count();
    nc = (classes_cfg == 0) ? 1 : (classes_cfg > 16) ? 16 : classes_cfg;
    r = '0;
    best = 0;
    if (nodata_on && pixel[0] == nodata_val) begin
      r.unclassified = 1'b1;
      return r;
    end
    for (int c = 0; c < nc; c++) begin
      for (int b = 0; b < nb; b++)
        diff[b] = $signed({48'd0, pixel[b]}) - $signed({48'd0, means[c][b]});
      mahal = 0;
      for (int rr = 0; rr < nb; rr++) begin
        row_sum = 0;
        for (int k = 0; k < nb; k++)
          row_sum += inv[c][rr][k] * diff[k];
        row_sum = (row_sum + 64'sd32768) >>> 16;
        mahal += diff[rr] * row_sum;
      end
      score = 2 * bias[c] - mahal;
      if (c == 0 || score > best) begin
        best = score;
        r.class_label = ids[c];
      end
    end
    return r;
  endfunction

  function void note_input(in_item_t it);
    case (it.operation)
      OP_SAMPLE: begin
        samples_seen++;
        if (band_idx < 8) pixel[band_idx] = it.band_sample;
        band_idx++;
        if (band_idx >= band_count()) begin
          band_idx = 0;
          queue_label(best_label());
        end
      end
      OP_ID: begin
        ids[it.table_class] = it.table_word[15:0];
        loads_seen++;
      end
      OP_BIAS: begin
        bias[it.table_class] = {{16{it.table_word[47]}}, it.table_word};
        loads_seen++;
      end
      OP_MEAN: begin
        means[it.table_class][it.table_row] = it.table_word[15:0];
        loads_seen++;
      end
      OP_INV: begin
        inv[it.table_class][it.table_row][it.table_col] =
          {{32{it.table_word[31]}}, it.table_word[31:0]};
        loads_seen++;
      end
      default: ;
    endcase
  endfunction

  function void check_result(out_item_t got);
    out_item_t want;
    if (pending_labels.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result item: label %0h unclassified %0b",
                 got.class_label, got.unclassified);
      return;
    end
    want = pending_labels.pop_front();
    results_seen++;
    if (want.unclassified) nodata_seen++;
    if (got.class_label !== want.class_label ||
        got.unclassified !== want.unclassified) begin
      errors++;
      if (errors <= 10)
        $display("result %0d: expected label %0h unclassified %0b, %s %0h %s %0b",
                 results_seen, want.class_label, want.unclassified,
                 "got label", got.class_label, "unclassified", got.unclassified);
    end
  endfunction
endclass

module tb_gaussian_max_likelihood_classifier;
  localparam int STALL_LIMIT  = 5000;
  localparam int RANDOM_ITEMS = 100;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  gmlc_in_if  in_ch ();
  gmlc_out_if out_ch ();

  gaussian_max_likelihood_classifier dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gmlc_scoreboard sb = new();

  int unsigned in_count;
  int unsigned out_count;
  int unsigned idle_cycles;
  bit          no_gaps;
  int          random_sent;

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // monitors on the rising edge, plus the watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note_input(in_ch.data);
        in_count++;
      end
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.data);
        out_count++;
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles == STALL_LIMIT) begin
          $display("timeout after %0d cycles without a handshake", STALL_LIMIT);
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  // result side: random stall before each item
  initial begin
    int n;
    int unsigned target;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      n = no_gaps ? 0 : $urandom_range(0, 12);
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      target = out_count + 1;
      do @(negedge clk); while (out_count < target);
    end
  end

  // send one item, waiting a random gap first
  task automatic send_item(in_item_t it);
    int gap;
    int unsigned target;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.data  <= it;
    in_ch.valid <= 1'b1;
    target = in_count + 1;
    do @(negedge clk); while (in_count < target);
  endtask

  task automatic send_op(op_t op, logic [3:0] cls, logic [2:0] rw, logic [2:0] cl,
                         logic [47:0] w, logic [15:0] s);
    in_item_t it;
    it.operation   = op;
    it.band_sample = s;
    it.table_class = cls;
    it.table_row   = rw;
    it.table_col   = cl;
    it.table_word  = w;
    send_item(it);
  endtask

  task automatic send_sample(logic [15:0] s);
    send_op(OP_SAMPLE, 4'($urandom), 3'($urandom), 3'($urandom), 48'({$urandom, $urandom}), s);
  endtask

  // wait until every expected result is in and the block has settled
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (sb.pending_labels.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_cfg(cfg_idx_t idx, logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // table values over a spread of magnitudes
  function automatic logic [47:0] any_word();
    logic [47:0] w;
    case ($urandom_range(0, 3))
      0: w = 48'({$urandom, $urandom});
      1: w = 48'(signed'($urandom_range(0, 8191)) - 4096);
      2: w = {{16{1'b0}}, 32'($urandom)} ^ ({48{$urandom_range(0, 1) == 1}} & 48'hFFFF_0000_0000);
      default: begin
        case ($urandom_range(0, 3))
          0: w = '0;
          1: w = '1;
          2: w = 48'h7FFF_FFFF_FFFF;
          default: w = 48'h8000_0000_0000;
        endcase
      end
    endcase
    return w;
  endfunction

  function automatic logic [3:0] pick_bands();
    case ($urandom_range(0, 9))
      0: return 4'd0;
      1: return 4'd8;
      2: return 4'($urandom_range(9, 15));
      3: return 4'($urandom_range(5, 7));
      default: return 4'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic logic [4:0] pick_classes();
    case ($urandom_range(0, 7))
      0: return 5'd0;
      1: return 5'd16;
      2: return 5'($urandom_range(17, 31));
      default: return 5'($urandom_range(1, 12));
    endcase
  endfunction

  initial begin
    int n_items;
    int kind;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_BANDS;
    cfg_data    = '0;
    rst_n       = 1'b0;
    no_gaps     = 1'b0;
    in_count    = 0;
    out_count   = 0;
    idle_cycles = 0;
    random_sent = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_cfg(CFG_BANDS, 16'd8);
    write_cfg(CFG_CLASSES, 16'd16);
    write_cfg(CFG_NDEN, 16'd0);
    write_cfg(CFG_NDVAL, 16'd0);

    // fill every slot of every table
    for (int c = 0; c < 16; c++) begin
      send_op(OP_ID, 4'(c), 3'($urandom), 3'($urandom), 48'({$urandom, $urandom}), 16'($urandom));
      send_op(OP_BIAS, 4'(c), 3'($urandom), 3'($urandom), any_word(), 16'($urandom));
      for (int r = 0; r < 8; r++) begin
        send_op(OP_MEAN, 4'(c), 3'(r), 3'($urandom), any_word(), 16'($urandom));
        for (int k = 0; k < 8; k++)
          send_op(OP_INV, 4'(c), 3'(r), 3'(k), any_word(), 16'($urandom));
      end
    end

    // directed: sample extremes over all bands
    for (int b = 0; b < 8; b++) send_sample(b[0] ? 16'hFFFF : 16'h0000);
    // ignored codes
    for (int op = 5; op < 8; op++) begin
      in_item_t it;
      it = in_item_t'({$urandom, $urandom, $urandom});
      it.operation = 3'(op);
      send_item(it);
    end

    // tie between slot 0 and slot 1, lowest slot wins
    drain();
    write_cfg(CFG_BANDS, 16'd1);
    write_cfg(CFG_CLASSES, 16'd2);
    send_op(OP_ID, 4'd1, 3'd0, 3'd0, 48'h0000_0000_FFFF, 16'd0);
    for (int c = 0; c < 2; c++) begin
      send_op(OP_BIAS, 4'(c), 3'd0, 3'd0, 48'h100, 16'd0);
      send_op(OP_MEAN, 4'(c), 3'd0, 3'd0, 48'd1000, 16'd0);
      send_op(OP_INV, 4'(c), 3'd0, 3'd0, 48'h0100_0000, 16'd0);
    end
    send_sample(16'd1200);
    // bias extremes decide the winner
    send_op(OP_BIAS, 4'd1, 3'd0, 3'd0, 48'h7FFF_FFFF_FFFF, 16'd0);
    send_sample(16'd0);
    send_op(OP_BIAS, 4'd1, 3'd0, 3'd0, 48'h8000_0000_0000, 16'd0);
    send_op(OP_MEAN, 4'd0, 3'd0, 3'd0, 48'hFFFF, 16'd0);
    send_op(OP_INV, 4'd0, 3'd0, 3'd0, 48'h0000_8000_0000, 16'd0);
    send_sample(16'hFFFF);

    // no-data pixel and a near miss
    drain();
    write_cfg(CFG_NDEN, 16'd1);
    write_cfg(CFG_NDVAL, 16'h1234);
    send_sample(16'h1234);
    send_sample(16'h1235);

    // band count lowered in the middle of a pixel
    drain();
    write_cfg(CFG_NDEN, 16'd0);
    write_cfg(CFG_BANDS, 16'd4);
    send_sample(16'($urandom));
    send_sample(16'($urandom));
    drain();
    write_cfg(CFG_BANDS, 16'd2);
    send_sample(16'($urandom));

    // random phases, each under fresh settings
    while (random_sent < RANDOM_ITEMS) begin
      drain();
      no_gaps = ($urandom_range(0, 4) == 0);
      write_cfg(CFG_BANDS, 16'(pick_bands()));
      write_cfg(CFG_CLASSES, 16'(pick_classes()));
      write_cfg(CFG_NDEN, 16'($urandom_range(0, 1)));
      case ($urandom_range(0, 3))
        0: write_cfg(CFG_NDVAL, 16'h0000);
        1: write_cfg(CFG_NDVAL, 16'hFFFF);
        default: write_cfg(CFG_NDVAL, 16'($urandom));
      endcase
      n_items = $urandom_range(20, 60);
      for (int i = 0; i < n_items; i++) begin
        kind = $urandom_range(0, 19);
        if (kind < 15) begin
          // band 0 sometimes hits the no-data value
          if (sb.band_idx == 0 && $urandom_range(0, 4) == 0)
            send_sample(sb.nodata_val);
          else if ($urandom_range(0, 9) == 0)
            send_sample($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
          else
            send_sample(16'($urandom));
          random_sent++;
        end else if (kind < 19) begin
          send_op(op_t'($urandom_range(1, 4)), 4'($urandom), 3'($urandom), 3'($urandom),
                  any_word(), 16'($urandom));
          random_sent++;
        end else begin
          in_item_t it;
          it = in_item_t'({$urandom, $urandom, $urandom});
          it.operation = 3'($urandom_range(5, 7));
          send_item(it);
        end
      end
    end

    drain();
    repeat (50) @(negedge clk);
    $display("covered %0d samples and %0d table loads, %0d results checked (%0d no-data)",
             sb.samples_seen, sb.loads_seen, sb.results_seen, sb.nodata_seen);
    if (sb.pending_labels.size() != 0) begin
      sb.errors++;
      $display("%0d expected results never arrived", sb.pending_labels.size());
    end
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches in total", sb.errors);
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

>>> files.f
src/gmlc_pkg.sv
src/gmlc_if.sv
src/gmlc_ctrl.sv
src/gmlc_dpath.sv
src/gaussian_max_likelihood_classifier.sv
verif/tb_gaussian_max_likelihood_classifier.sv
